// ----- rtl/cold_tone_curve_pixel_map_defines.svh -----
// Assertion macros for the tone curve block.
`ifndef COLD_TONE_CURVE_PIXEL_MAP_DEFINES_SVH
`define COLD_TONE_CURVE_PIXEL_MAP_DEFINES_SVH

// Same-cycle implication under reset.
`define CTC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under reset.
`define CTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ctcpm_pkg.sv -----
`default_nettype none

package ctcpm_pkg;

  localparam int unsigned KnotCountDefault = 6;
  localparam int unsigned KnotRegCount     = 6;
  localparam int unsigned CfgWidth         = 8 * KnotRegCount;
  localparam int unsigned CfgIndexWidth    = 2;
  localparam int unsigned LevelWidth       = 8;
  localparam int unsigned LutDepth         = 1 << LevelWidth;
  localparam int unsigned DivBits          = 2 * LevelWidth;
  localparam int unsigned StepWidth        = $clog2(DivBits);

  localparam logic [CfgWidth-1:0] KnotInputsReset = 48'hFFC896643200;
  localparam logic [CfgWidth-1:0] RedOutputsReset = 48'hFF964B281400;
  localparam logic [CfgWidth-1:0] BlueOutputsReset = 48'hFFDCBE965000;

  localparam logic [CfgIndexWidth-1:0] CfgKnotInputs  = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CfgRedOutputs  = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CfgBlueOutputs = 2'd2;

  // Channel slots in the curve datapath.
  localparam int unsigned ChBlue  = 0;
  localparam int unsigned ChRed   = 1;
  localparam int unsigned ChCount = 2;

  typedef struct packed {
    logic [LevelWidth-1:0] blue_in;
    logic [LevelWidth-1:0] green_in;
    logic [LevelWidth-1:0] red_in;
    logic [LevelWidth-1:0] alpha_in;
  } pixel_in_t;

  typedef struct packed {
    logic [LevelWidth-1:0] blue_out;
    logic [LevelWidth-1:0] green_out;
    logic [LevelWidth-1:0] red_out;
    logic [LevelWidth-1:0] alpha_out;
  } pixel_out_t;

  typedef struct packed {
    logic [LevelWidth-1:0] dval;
    logic                  neg;
    logic [LevelWidth-1:0] ylo;
  } chan_eval_t;

  // Knots past the register width read as zero.
  function automatic logic [LevelWidth-1:0] knot_byte(logic [CfgWidth-1:0] r,
                                                      int unsigned k);
    logic [LevelWidth-1:0] b;
    b = '0;
    if (k < KnotRegCount) begin
      b = r[k*LevelWidth +: LevelWidth];
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cold_tone_curve_pixel_map.sv -----
// Maps red and blue of each BGRA pixel through two piecewise-linear tone curves
// that share one set of knot levels; green and alpha pass through. The curves
// live in two 256-entry lookup memories (one per channel) indexed by the input
// level, so the pixel path takes one pixel per clock, once the tables are built and
// while the output is not stalled, through a lookup stage and an output register.
// After reset and after every configuration write the tables are rebuilt by a
// sequencer that evaluates one level at a time through a 16-step shift-subtract
// divider, and in_ready_o stays low until the rebuild is done. Configuration
// writes are always taken and restart the rebuild; an unmapped index stores nothing.
`default_nettype none

`include "cold_tone_curve_pixel_map_defines.svh"

module cold_tone_curve_pixel_map
  import ctcpm_pkg::*;
#(
  parameter int unsigned KNOT_COUNT = KnotCountDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  output      logic                     cfg_ready_o,
  input  wire logic [CfgIndexWidth-1:0] cfg_index_i,
  input  wire logic [CfgWidth-1:0]      cfg_data_i,
  input  wire logic                     in_valid_i,
  output      logic                     in_ready_o,
  input  wire pixel_in_t                in_pixel_i,
  output      logic                     out_valid_o,
  input  wire logic                     out_ready_i,
  output      pixel_out_t               out_pixel_o
);

  localparam int unsigned KW = $clog2(KNOT_COUNT);
  localparam logic [KW-1:0] LastKnot = KW'(KNOT_COUNT - 1);

  typedef enum logic [1:0] {
    SeqEval,
    SeqDiv,
    SeqWrite,
    SeqDone
  } seq_state_e;

  // Configuration registers
  logic [CfgWidth-1:0] knot_x_q, red_y_q, blue_y_q;
  logic                cfg_accept;

  assign cfg_ready_o = 1'b1;
  assign cfg_accept  = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      knot_x_q <= KnotInputsReset;
      red_y_q  <= RedOutputsReset;
      blue_y_q <= BlueOutputsReset;
    end else if (cfg_accept) begin
      case (cfg_index_i)
        CfgKnotInputs:  knot_x_q <= cfg_data_i;
        CfgRedOutputs:  red_y_q  <= cfg_data_i;
        CfgBlueOutputs: blue_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Table rebuild sequencer
  seq_state_e              seq_state_q;
  logic [LevelWidth-1:0]   seq_a_q;
  logic [StepWidth-1:0]    step_q;
  logic                    built;

  logic                    direct_q;
  logic [LevelWidth-1:0]   den_q;
  chan_eval_t              chan_q   [ChCount];
  logic [LevelWidth-1:0]   rem_q    [ChCount];
  logic [DivBits-1:0]      quo_q    [ChCount];

  logic [LevelWidth-1:0]   xs       [KNOT_COUNT];
  logic [LevelWidth-1:0]   ys       [ChCount][KNOT_COUNT];
  logic [KW-1:0]           j_idx, jm1_idx;
  logic                    found;
  logic                    direct_d;
  logic [LevelWidth-1:0]   den_d, da_d;
  chan_eval_t              chan_d   [ChCount];
  logic [DivBits-1:0]      mag_d    [ChCount];
  logic [LevelWidth-1:0]   rem_d    [ChCount];
  logic [DivBits-1:0]      quo_d    [ChCount];
  logic [LevelWidth-1:0]   res      [ChCount];
  logic                    wr_en;

  assign built = (seq_state_q == SeqDone);
  assign wr_en = (seq_state_q == SeqWrite);

  always_comb begin
    logic [LevelWidth:0]   dy;
    logic [LevelWidth-1:0] dy_abs;
    for (int k = 0; k < KNOT_COUNT; k++) begin
      xs[k]        = knot_byte(knot_x_q, k);
      ys[ChBlue][k] = knot_byte(blue_y_q, k);
      ys[ChRed][k]  = knot_byte(red_y_q, k);
    end
    found = 1'b0;
    j_idx = '0;
    for (int k = KNOT_COUNT - 1; k >= 0; k--) begin
      if (xs[k] >= seq_a_q) begin
        found = 1'b1;
        j_idx = KW'(k);
      end
    end
    jm1_idx  = (j_idx == '0) ? '0 : j_idx - 1'b1;
    direct_d = !found || (xs[j_idx] == seq_a_q) || (j_idx == '0);
    den_d    = xs[j_idx] - xs[jm1_idx];
    da_d     = seq_a_q - xs[jm1_idx];
    for (int c = 0; c < ChCount; c++) begin
      dy              = {1'b0, ys[c][j_idx]} - {1'b0, ys[c][jm1_idx]};
      dy_abs          = dy[LevelWidth] ? LevelWidth'(-dy) : dy[LevelWidth-1:0];
      chan_d[c].dval  = found ? ys[c][j_idx] : ys[c][LastKnot];
      chan_d[c].neg   = dy[LevelWidth];
      chan_d[c].ylo   = ys[c][jm1_idx];
      mag_d[c]        = DivBits'(dy_abs) * DivBits'(da_d);
    end
  end

  // One restoring divide step per channel
  always_comb begin
    logic [LevelWidth:0] rs;
    logic                ge;
    for (int c = 0; c < ChCount; c++) begin
      rs       = {rem_q[c], quo_q[c][DivBits-1]};
      ge       = (rs >= {1'b0, den_q});
      rem_d[c] = ge ? LevelWidth'(rs - {1'b0, den_q}) : rs[LevelWidth-1:0];
      quo_d[c] = {quo_q[c][DivBits-2:0], ge};
    end
  end

  // Floor toward minus infinity on a falling segment
  always_comb begin
    logic [LevelWidth-1:0] q;
    for (int c = 0; c < ChCount; c++) begin
      q = quo_q[c][LevelWidth-1:0]
          + LevelWidth'(chan_q[c].neg && (rem_q[c] != '0));
      if (direct_q) begin
        res[c] = chan_q[c].dval;
      end else if (chan_q[c].neg) begin
        res[c] = chan_q[c].ylo - q;
      end else begin
        res[c] = chan_q[c].ylo + q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_state_q <= SeqEval;
      seq_a_q     <= '0;
      step_q      <= '0;
    end else if (cfg_accept) begin
      seq_state_q <= SeqEval;
      seq_a_q     <= '0;
      step_q      <= '0;
    end else begin
      case (seq_state_q)
        SeqEval: begin
          seq_state_q <= SeqDiv;
          step_q      <= '0;
        end
        SeqDiv: begin
          step_q <= step_q + 1'b1;
          if (step_q == StepWidth'(DivBits - 1)) begin
            seq_state_q <= SeqWrite;
          end
        end
        SeqWrite: begin
          seq_a_q <= seq_a_q + 1'b1;
          if (seq_a_q == LevelWidth'(LutDepth - 1)) begin
            seq_state_q <= SeqDone;
          end else begin
            seq_state_q <= SeqEval;
          end
        end
        SeqDone: ;
        default: seq_state_q <= SeqEval;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_state_q == SeqEval) begin
      direct_q <= direct_d;
      den_q    <= den_d;
      for (int c = 0; c < ChCount; c++) begin
        chan_q[c] <= chan_d[c];
        rem_q[c]  <= '0;
        quo_q[c]  <= mag_d[c];
      end
    end else if (seq_state_q == SeqDiv) begin
      for (int c = 0; c < ChCount; c++) begin
        rem_q[c] <= rem_d[c];
        quo_q[c] <= quo_d[c];
      end
    end
  end

  // Curve tables; writes only while rebuilding, reads only once built
  logic [LevelWidth-1:0] blue_lut [LutDepth];
  logic [LevelWidth-1:0] red_lut  [LutDepth];
  logic [LevelWidth-1:0] blue_rd_q, red_rd_q;
  logic                  in_accept;

  assign in_accept = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      blue_lut[seq_a_q] <= res[ChBlue];
      red_lut[seq_a_q]  <= res[ChRed];
    end
    if (in_accept) begin
      blue_rd_q <= blue_lut[in_pixel_i.blue_in];
      red_rd_q  <= red_lut[in_pixel_i.red_in];
    end
  end

  // Pixel pipeline: lookup stage then output register
  logic                  s1_valid_q, out_valid_q;
  logic [LevelWidth-1:0] s1_green_q, s1_alpha_q;
  pixel_out_t            out_q;
  logic                  s1_move;

  assign s1_move     = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o  = built & (~s1_valid_q | s1_move);
  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= in_accept | (s1_valid_q & ~s1_move);
      out_valid_q <= s1_move | (out_valid_q & ~out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_green_q <= in_pixel_i.green_in;
      s1_alpha_q <= in_pixel_i.alpha_in;
    end
    if (s1_move) begin
      out_q.blue_out  <= blue_rd_q;
      out_q.green_out <= s1_green_q;
      out_q.red_out   <= red_rd_q;
      out_q.alpha_out <= s1_alpha_q;
    end
  end

  `CTC_ASSERT_NOW(a_no_rd_during_wr, clk_i, rst_ni, wr_en, !in_accept, "pixel accepted during table rebuild")
  `CTC_ASSERT_NEXT(a_cfg_restarts, clk_i, rst_ni, cfg_accept, (seq_state_q == SeqEval) && (seq_a_q == '0), "config write did not restart rebuild")
  `CTC_ASSERT_NOW(a_rem_blue, clk_i, rst_ni, (seq_state_q == SeqDiv) && !direct_q, rem_q[ChBlue] < den_q, "blue divider remainder out of range")
  `CTC_ASSERT_NOW(a_rem_red, clk_i, rst_ni, (seq_state_q == SeqDiv) && !direct_q, rem_q[ChRed] < den_q, "red divider remainder out of range")
  `CTC_ASSERT_NEXT(a_accept_to_s1, clk_i, rst_ni, in_accept, s1_valid_q, "accepted pixel lost before lookup stage")

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ctcpm_pkg::*;

  localparam int unsigned KNOTS = KnotCountDefault;
  localparam logic [CfgIndexWidth-1:0] CfgUnmapped = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PRINT_LIMIT = 40;

  localparam logic [CfgWidth-1:0] DefaultKnots = 48'hFFC896643200;
  localparam logic [CfgWidth-1:0] DefaultRed   = 48'hFF964B281400;
  localparam logic [CfgWidth-1:0] DefaultBlue  = 48'hFFDCBE965000;

  class tone_curve_scoreboard;
    logic [CfgWidth-1:0] knot_levels;
    logic [CfgWidth-1:0] red_levels;
    logic [CfgWidth-1:0] blue_levels;
    pixel_out_t expected_pixels[$];
    int error_count;

    function new();
      knot_levels = DefaultKnots;
      red_levels  = DefaultRed;
      blue_levels = DefaultBlue;
      error_count = 0;
    endfunction

    function int level_at(logic [CfgWidth-1:0] packed_levels, int k);
      if (k >= KnotRegCount) return 0;
      return int'(packed_levels[k*8 +: 8]);
    endfunction

    function logic [7:0] map_through_curve(logic [7:0] level, logic [CfgWidth-1:0] ys);
      int seg;
      int a;
      int xlo;
      int ylo;
      int num;
      int den;
      int quot;
      a = int'(level);
      seg = KNOTS;
      for (int k = KNOTS - 1; k >= 0; k--) begin
        if (level_at(knot_levels, k) >= a) seg = k;
      end
      if (seg == KNOTS) return 8'(level_at(ys, KNOTS - 1));
      if (level_at(knot_levels, seg) == a || seg == 0) return 8'(level_at(ys, seg));
      xlo = level_at(knot_levels, seg - 1);
      ylo = level_at(ys, seg - 1);
      num = (level_at(ys, seg) - ylo) * (a - xlo);
      den = level_at(knot_levels, seg) - xlo;
      // floor toward minus infinity on falling segments
      if (num >= 0) quot = num / den;
      else quot = -((-num + den - 1) / den);
      return 8'(ylo + quot);
    endfunction

    function void write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgWidth-1:0] data);
      case (idx)
        CfgKnotInputs:  knot_levels = data;
        CfgRedOutputs:  red_levels  = data;
        CfgBlueOutputs: blue_levels = data;
        default: ;
      endcase
    endfunction

    function void note_pixel(pixel_in_t px);
      pixel_out_t want;
      want.blue_out  = map_through_curve(px.blue_in, blue_levels);
      want.green_out = px.green_in;
      want.red_out   = map_through_curve(px.red_in, red_levels);
      want.alpha_out = px.alpha_in;
      expected_pixels.push_back(want);
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    task report(string what);
      error_count++;
      if (error_count <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_pixel(pixel_out_t got);
      pixel_out_t want;
      if (expected_pixels.size() == 0) begin
        report($sformatf("result %h with no transaction outstanding", got));
        return;
      end
      want = expected_pixels.pop_front();
      if (got.blue_out !== want.blue_out)
        report($sformatf("blue_out %0d, expected %0d", got.blue_out, want.blue_out));
      if (got.green_out !== want.green_out)
        report($sformatf("green_out %0d, expected %0d", got.green_out, want.green_out));
      if (got.red_out !== want.red_out)
        report($sformatf("red_out %0d, expected %0d", got.red_out, want.red_out));
      if (got.alpha_out !== want.alpha_out)
        report($sformatf("alpha_out %0d, expected %0d", got.alpha_out, want.alpha_out));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgWidth-1:0] cfg_data = '0;
  logic pix_valid = 1'b0;
  logic pix_ready;
  pixel_in_t pix_in = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  pixel_out_t res_out;

  tone_curve_scoreboard sb = new();
  logic [CfgWidth-1:0] cur_knots = DefaultKnots;
  bit sender_burst = 1'b0;
  int idle_cycles = 0;

  cold_tone_curve_pixel_map dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (pix_valid),
    .in_ready_o  (pix_ready),
    .in_pixel_i  (pix_in),
    .out_valid_o (res_valid),
    .out_ready_i (res_ready),
    .out_pixel_o (res_out)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    bit moved;
    moved = 1'b0;
    if (cfg_valid && cfg_ready) begin
      sb.write_reg(cfg_index, cfg_data);
      moved = 1'b1;
    end
    if (pix_valid && pix_ready) begin
      sb.note_pixel(pix_in);
      moved = 1'b1;
    end
    if (res_valid && res_ready) begin
      sb.check_pixel(res_out);
      moved = 1'b1;
    end
    if (moved) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL cold_tone_curve_pixel_map");
      $finish;
    end
  end

  // sink side: random stalls, one long hold-off to back up the pipe
  initial begin
    int gap;
    int taken;
    bit burst;
    bit held;
    taken = 0;
    burst = 1'b0;
    held = 1'b0;
    forever begin
      if (taken == 500 && !held) begin
        held = 1'b1;
        res_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        gap = burst ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 49) == 0) burst = !burst;
        if (gap > 0) begin
          res_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
      taken++;
    end
  end

  task automatic send_pixel(input pixel_in_t px);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 12);
    if ($urandom_range(0, 39) == 0) sender_burst = !sender_burst;
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_in <= px;
    pix_valid <= 1'b1;
    do @(posedge clk); while (!pix_ready);
  endtask

  task automatic load_curves(input logic [CfgWidth-1:0] xs, input logic [CfgWidth-1:0] rs,
                             input logic [CfgWidth-1:0] bs, input bit poke_unmapped);
    logic [CfgIndexWidth-1:0] idx[4];
    logic [CfgWidth-1:0] val[4];
    int n;
    idx = '{CfgKnotInputs, CfgRedOutputs, CfgBlueOutputs, CfgUnmapped};
    val = '{xs, rs, bs, 48'({$urandom(), $urandom()})};
    n = poke_unmapped ? 4 : 3;
    cfg_valid <= 1'b1;
    for (int i = 0; i < n; i++) begin
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic pixel_in_t random_pixel();
    pixel_in_t px;
    logic [7:0] lvl[2];
    int pick;
    for (int c = 0; c < 2; c++) begin
      pick = $urandom_range(0, 7);
      lvl[c] = cur_knots[$urandom_range(0, KNOTS - 1) * 8 +: 8];
      if (pick == 2) lvl[c] = lvl[c] + 8'd1;
      else if (pick == 3) lvl[c] = lvl[c] - 8'd1;
      else if (pick > 3) lvl[c] = 8'($urandom_range(0, 255));
    end
    px.blue_in  = lvl[0];
    px.green_in = 8'($urandom_range(0, 255));
    px.red_in   = lvl[1];
    px.alpha_in = 8'($urandom_range(0, 255));
    return px;
  endfunction

  function automatic logic [CfgWidth-1:0] rising_knots();
    logic [CfgWidth-1:0] xs;
    int prev;
    xs = '0;
    xs[47:40] = 8'hFF;
    prev = 0;
    for (int k = 1; k < 5; k++) begin
      prev = $urandom_range(prev + 1, 246 + k);
      xs[k*8 +: 8] = 8'(prev);
    end
    return xs;
  endfunction

  task automatic run_curves(input int count, input logic [CfgWidth-1:0] xs,
                            input logic [CfgWidth-1:0] rs, input logic [CfgWidth-1:0] bs,
                            input bit poke_unmapped);
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    load_curves(xs, rs, bs, poke_unmapped);
    cur_knots = xs;
    repeat (count) send_pixel(random_pixel());
    pix_valid <= 1'b0;
  endtask

  initial begin
    byte unsigned probe_levels[16];
    pixel_in_t px;
    probe_levels = '{0, 1, 25, 49, 50, 51, 99, 100, 149, 150, 175, 199, 200, 201, 254, 255};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // knots, neighbors and extremes on the reset curves
    foreach (probe_levels[i]) begin
      px.red_in   = probe_levels[i];
      px.blue_in  = 8'd255 - probe_levels[i];
      px.green_in = probe_levels[i] ^ 8'hA5;
      px.alpha_in = ~probe_levels[i];
      send_pixel(px);
    end
    pix_valid <= 1'b0;

    run_curves(130, DefaultKnots, DefaultRed, DefaultBlue, 1'b1);
    for (int i = 0; i < 3; i++)
      run_curves(100, rising_knots(), 48'({$urandom(), $urandom()}),
                 48'({$urandom(), $urandom()}), 1'b0);
    // falling red curve
    run_curves(100, DefaultKnots, 48'h001450A0C8FF, 48'({$urandom(), $urandom()}), 1'b0);
    // flat knot sets: everything at one level
    run_curves(80, 48'h000000000000, 48'hFFFFFFFFFFFF, 48'h000000000000, 1'b0);
    run_curves(80, 48'hFFFFFFFFFFFF, 48'({$urandom(), $urandom()}),
               48'({$urandom(), $urandom()}), 1'b0);
    // levels below the first knot and above the last
    run_curves(120, 48'hF0C89664321E, 48'({$urandom(), $urandom()}),
               48'({$urandom(), $urandom()}), 1'b1);
    // arbitrary, mostly non-monotonic knots
    for (int i = 0; i < 2; i++)
      run_curves(100, 48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
                 48'({$urandom(), $urandom()}), 1'b0);
    // steep alternating segments
    run_curves(100, 48'hFFFEFD020100, 48'hFF00FF00FF00, 48'h00FF00FF00FF, 1'b0);
    run_curves(60, DefaultKnots, DefaultRed, DefaultBlue, 1'b1);

    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("PASS cold_tone_curve_pixel_map");
    end else begin
      $display("FAIL cold_tone_curve_pixel_map");
    end
    $finish;
  end

endmodule
